### sv/safc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package safc_pkg;

	localparam int CACHE_SIZE = 4096;
	localparam int LINE_SIZE  = 16;
	localparam int LINE_HALF  = LINE_SIZE / 2;
	localparam int ADDR_W     = $clog2(CACHE_SIZE);
	localparam int LANE_W     = $clog2(LINE_SIZE);
	localparam int LINE_W     = ADDR_W - LANE_W;
	localparam int CNT_W      = LANE_W + 1;
	localparam int CFG_IDX_W  = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INACTIVE = 8'd1;

	localparam logic [15:0] ACTIVE_RESET   = 16'd300;
	localparam logic [15:0] INACTIVE_RESET = 16'd30;

	localparam logic [7:0] SYN_MASK = 8'h02;
	localparam logic [7:0] END_MASK = 8'h05;

	localparam logic [1:0] REASON_ACTIVE    = 2'd0;
	localparam logic [1:0] REASON_INACTIVE  = 2'd1;
	localparam logic [1:0] REASON_END       = 2'd2;
	localparam logic [1:0] REASON_COLLISION = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [63:0] hash;
		logic [31:0] first_seen;
		logic [31:0] last_seen;
		logic [7:0]  flags;
		logic [31:0] packets;
	} ent_t;

	typedef struct packed {
		logic [63:0] hash;
		logic [1:0]  reason;
		logic [31:0] packets;
		logic [31:0] first_seen;
		logic [31:0] last_seen;
		logic [7:0]  flags;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_RD, ST_LOOK, ST_UPD, ST_WB, ST_SRD, ST_SCHK, ST_FLUSH
	} state_t;

	typedef struct packed {
		logic              clr_wr;
		logic              latch;
		logic              rd;
		logic              cap;
		logic              look;
		logic              upd;
		logic              wb;
		logic              srd;
		logic              schk;
		logic              flush;
		logic [LANE_W-1:0] idx;
		logic [ADDR_W-1:0] caddr;
	} cmd_t;

	typedef struct packed {
		logic look_emit;
		logic upd_emit;
		logic scan_emit;
		logic can_push;
		logic pend_v;
		logic out_free;
	} sts_t;

	// True when now is not below then and now - then reaches the limit.
	function automatic logic expired(logic [31:0] now, logic [31:0] then,
		logic [15:0] limit);
		logic [32:0] d;
		d = {1'b0, now} - {1'b0, then};
		return !d[32] && (d[31:0] >= {16'd0, limit});
	endfunction

endpackage
`default_nettype wire

### sv/safc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface safc_pkt_if;
	logic        valid;
	logic        ready;
	logic [63:0] flow_hash;
	logic [31:0] timestamp_s;
	logic [7:0]  flag_byte;
	modport source (output valid, output flow_hash, output timestamp_s, output flag_byte,
		input ready);
	modport sink (input valid, input flow_hash, input timestamp_s, input flag_byte,
		output ready);
endinterface

interface safc_rec_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_hash;
	logic [1:0]  out_reason;
	logic [31:0] out_packets;
	logic [31:0] out_first_seen;
	logic [31:0] out_last_seen;
	logic [7:0]  out_flags;
	logic        out_last;
	modport source (output valid, output out_hash, output out_reason, output out_packets,
		output out_first_seen, output out_last_seen, output out_flags, output out_last,
		input ready);
	modport sink (input valid, input out_hash, input out_reason, input out_packets,
		input out_first_seen, input out_last_seen, input out_flags, input out_last,
		output ready);
endinterface

interface safc_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/set_associative_flow_cache.sv
// Flow cache with active and inactive timeouts, organized as lines of
// sixteen entries in a 4096-entry table.
// Requests arrive on pkt (flow hash, arrival second, TCP flags). Each request
// may export several flow records on rec; the final record caused by a
// request carries out_last. A request that exports nothing produces no record.
// Timeouts are written on cfg (index 0 active, index 1 inactive, in seconds);
// the user must write them only while the block is idle, as the block itself
// does not enforce it. Other indexes are ignored. cfg is always ready.
// A request is taken, its line is read from the single-port table, looked
// up and updated, written back, and then eight entries are scanned for
// inactive flows before the last record is released. Records are held in a
// one-deep pending stage and an output register; when rec stalls, the block
// waits at the next export. After reset the table is cleared one entry per
// cycle while pkt is not ready. Timeouts return to 300 and 30 seconds.
`timescale 1ns / 1ps
`default_nettype none
module set_associative_flow_cache (
	input  wire logic  clk,
	input  wire logic  arst_n,
	safc_pkt_if.sink   pkt,
	safc_rec_if.source rec,
	safc_cfg_if.sink   cfg
);

	logic [15:0] active_to_q, inactive_to_q;
	safc_pkg::cmd_t cmd;
	safc_pkg::sts_t sts;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_to_q   <= safc_pkg::ACTIVE_RESET;
			inactive_to_q <= safc_pkg::INACTIVE_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == safc_pkg::CFG_ACTIVE) active_to_q <= cfg.data;
			if (cfg.index == safc_pkg::CFG_INACTIVE) inactive_to_q <= cfg.data;
		end
	end

	// The sequencer walks the line read, lookup, write-back and scan steps.
	safc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pkt.valid),
		.in_ready (pkt.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the table, the line buffer and the record stages.
	safc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.flow_hash   (pkt.flow_hash),
		.timestamp_s (pkt.timestamp_s),
		.flag_byte   (pkt.flag_byte),
		.active_to   (active_to_q),
		.inactive_to (inactive_to_q),
		.cmd         (cmd),
		.sts         (sts),
		.rec         (rec)
	);

endmodule
`default_nettype wire

### sv/safc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module safc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire safc_pkg::sts_t  sts,
	output safc_pkg::cmd_t       cmd
);

	safc_pkg::state_t state_q, state_d;
	logic [safc_pkg::ADDR_W-1:0] clr_q;
	logic [safc_pkg::CNT_W-1:0]  cnt_q;
	logic rd_end, wb_end, scan_end, look_go, upd_go, schk_go, flush_go;

	assign rd_end   = cnt_q == safc_pkg::CNT_W'(safc_pkg::LINE_SIZE);
	assign wb_end   = cnt_q == safc_pkg::CNT_W'(safc_pkg::LINE_SIZE - 1);
	assign scan_end = cnt_q == safc_pkg::CNT_W'(safc_pkg::LINE_HALF - 1);
	assign look_go  = !sts.look_emit || sts.can_push;
	assign upd_go   = !sts.upd_emit || sts.can_push;
	assign schk_go  = !sts.scan_emit || sts.can_push;
	assign flush_go = !sts.pend_v || sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			safc_pkg::ST_CLR:   if (&clr_q) state_d = safc_pkg::ST_IDLE;
			safc_pkg::ST_IDLE:  if (in_valid) state_d = safc_pkg::ST_RD;
			safc_pkg::ST_RD:    if (rd_end) state_d = safc_pkg::ST_LOOK;
			safc_pkg::ST_LOOK:  if (look_go) state_d = safc_pkg::ST_UPD;
			safc_pkg::ST_UPD: begin
				if (upd_go) state_d = sts.upd_emit ? safc_pkg::ST_LOOK : safc_pkg::ST_WB;
			end
			safc_pkg::ST_WB:    if (wb_end) state_d = safc_pkg::ST_SRD;
			safc_pkg::ST_SRD:   state_d = safc_pkg::ST_SCHK;
			safc_pkg::ST_SCHK: begin
				if (schk_go) state_d = scan_end ? safc_pkg::ST_FLUSH : safc_pkg::ST_SRD;
			end
			safc_pkg::ST_FLUSH: if (flush_go) state_d = safc_pkg::ST_IDLE;
			default:            state_d = safc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.idx   = cnt_q[safc_pkg::LANE_W-1:0];
		cmd.caddr = clr_q;
		in_ready  = 1'b0;
		unique case (state_q)
			safc_pkg::ST_CLR:   cmd.clr_wr = 1'b1;
			safc_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			safc_pkg::ST_RD: begin
				cmd.rd  = !rd_end;
				cmd.cap = cnt_q != '0;
			end
			safc_pkg::ST_LOOK:  cmd.look = look_go;
			safc_pkg::ST_UPD:   cmd.upd = upd_go;
			safc_pkg::ST_WB:    cmd.wb = 1'b1;
			safc_pkg::ST_SRD:   cmd.srd = 1'b1;
			safc_pkg::ST_SCHK:  cmd.schk = schk_go;
			safc_pkg::ST_FLUSH: cmd.flush = flush_go;
			default:            cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= safc_pkg::ST_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == safc_pkg::ST_CLR) clr_q <= clr_q + 1'b1;
			case (state_q)
				safc_pkg::ST_RD:   cnt_q <= rd_end ? '0 : cnt_q + 1'b1;
				safc_pkg::ST_WB:   cnt_q <= wb_end ? '0 : cnt_q + 1'b1;
				safc_pkg::ST_SCHK: if (schk_go) cnt_q <= scan_end ? '0 : cnt_q + 1'b1;
				default:           ;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/safc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module safc_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [63:0]     flow_hash,
	input  wire logic [31:0]     timestamp_s,
	input  wire logic [7:0]      flag_byte,
	input  wire logic [15:0]     active_to,
	input  wire logic [15:0]     inactive_to,
	input  wire safc_pkg::cmd_t  cmd,
	output safc_pkg::sts_t       sts,
	safc_rec_if.source           rec
);

	safc_pkg::ent_t mem [safc_pkg::CACHE_SIZE];
	safc_pkg::ent_t rdata_q;
	safc_pkg::ent_t lanes_q [safc_pkg::LINE_SIZE];
	safc_pkg::ent_t w_q, new_ent, hit_ent, empty_ent;
	safc_pkg::res_t pend_q, out_q, push_res, col_res, upd_res, scan_res;
	logic pend_v_q, out_v_q, out_last_q;
	logic [63:0] hash_q;
	logic [31:0] ts_q;
	logic [7:0]  flags_q;
	logic [safc_pkg::LANE_W-1:0] s_q, hit_idx, free_idx;
	logic [safc_pkg::ADDR_W-1:0] sp_q, scan_addr, line_addr, maddr;
	logic hit, free_any, we, re, push;
	logic syn_end, inact, act, scan_exp;

	function automatic logic has_syn(logic [7:0] f);
		return (f & safc_pkg::SYN_MASK) != '0;
	endfunction

	assign line_addr = {hash_q[safc_pkg::ADDR_W-1:safc_pkg::LANE_W], cmd.idx};
	assign scan_addr = sp_q + safc_pkg::ADDR_W'(cmd.idx);

	always_comb begin
		empty_ent       = '0;
		hit             = 1'b0;
		free_any        = 1'b0;
		hit_idx         = '0;
		free_idx        = '0;
		for (int i = safc_pkg::LINE_SIZE - 1; i >= 0; i--) begin
			if (lanes_q[i].valid && lanes_q[i].hash == hash_q) begin
				hit     = 1'b1;
				hit_idx = safc_pkg::LANE_W'(i);
			end
			if (!lanes_q[i].valid) begin
				free_any = 1'b1;
				free_idx = safc_pkg::LANE_W'(i);
			end
		end
		hit_ent = lanes_q[hit_idx];
	end

	// Decision on the selected entry, in the order end-of-flow, inactive, active.
	assign syn_end = has_syn(flags_q) && ((w_q.flags & safc_pkg::END_MASK) != '0);
	assign inact = safc_pkg::expired(ts_q, w_q.last_seen, inactive_to);
	assign act   = safc_pkg::expired(ts_q, w_q.first_seen, active_to);

	always_comb begin
		new_ent = w_q;
		if (!w_q.valid) begin
			new_ent = {1'b1, hash_q, ts_q, ts_q, flags_q, 32'd1};
		end else if (syn_end || inact || act) begin
			new_ent.valid = 1'b0;
		end else begin
			new_ent.last_seen = ts_q;
			new_ent.flags     = w_q.flags | flags_q;
			if (w_q.packets != '1) new_ent.packets = w_q.packets + 32'd1;
		end
	end

	assign col_res = {lanes_q[safc_pkg::LINE_SIZE-1].hash, safc_pkg::REASON_COLLISION,
		lanes_q[safc_pkg::LINE_SIZE-1].packets, lanes_q[safc_pkg::LINE_SIZE-1].first_seen,
		lanes_q[safc_pkg::LINE_SIZE-1].last_seen, lanes_q[safc_pkg::LINE_SIZE-1].flags};
	assign upd_res = {w_q.hash, syn_end ? safc_pkg::REASON_END :
		(inact ? safc_pkg::REASON_INACTIVE : safc_pkg::REASON_ACTIVE),
		w_q.packets, w_q.first_seen, w_q.last_seen, w_q.flags};
	assign scan_exp = rdata_q.valid &&
		safc_pkg::expired(ts_q, rdata_q.last_seen, inactive_to);
	assign scan_res = {rdata_q.hash, ((rdata_q.flags & safc_pkg::END_MASK) != '0) ?
		safc_pkg::REASON_END : safc_pkg::REASON_INACTIVE,
		rdata_q.packets, rdata_q.first_seen, rdata_q.last_seen, rdata_q.flags};

	assign sts.look_emit = !hit && !free_any;
	assign sts.upd_emit  = w_q.valid && (syn_end || inact || act);
	assign sts.scan_emit = scan_exp;
	assign sts.can_push  = !pend_v_q || !out_v_q || rec.ready;
	assign sts.pend_v    = pend_v_q;
	assign sts.out_free  = !out_v_q || rec.ready;

	assign push = (cmd.look && sts.look_emit) || (cmd.upd && sts.upd_emit) ||
		(cmd.schk && scan_exp);
	always_comb begin
		if (cmd.look) push_res = col_res;
		else if (cmd.upd) push_res = upd_res;
		else push_res = scan_res;
	end

	// Table port: one access per cycle, read data registered.
	assign we    = cmd.clr_wr || cmd.wb || (cmd.schk && scan_exp);
	assign re    = cmd.rd || cmd.srd;
	assign maddr = cmd.clr_wr ? cmd.caddr : ((cmd.wb || cmd.rd) ? line_addr : scan_addr);

	always_ff @(posedge clk) begin
		if (we) mem[maddr] <= cmd.wb ? lanes_q[0] : empty_ent;
		if (re) rdata_q <= mem[maddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			hash_q  <= flow_hash;
			ts_q    <= timestamp_s;
			flags_q <= flag_byte;
		end
		if (cmd.cap) begin
			for (int i = 0; i < safc_pkg::LINE_SIZE - 1; i++) lanes_q[i] <= lanes_q[i+1];
			lanes_q[safc_pkg::LINE_SIZE-1] <= rdata_q;
		end else if (cmd.wb) begin
			for (int i = 0; i < safc_pkg::LINE_SIZE - 1; i++) lanes_q[i] <= lanes_q[i+1];
		end else if (cmd.look) begin
			if (hit) begin
				lanes_q[0] <= hit_ent;
				for (int i = 1; i < safc_pkg::LINE_SIZE; i++) begin
					if (safc_pkg::LANE_W'(i) <= hit_idx) lanes_q[i] <= lanes_q[i-1];
				end
				w_q <= hit_ent;
				s_q <= '0;
			end else if (free_any) begin
				w_q <= empty_ent;
				s_q <= free_idx;
			end else begin
				for (int i = safc_pkg::LINE_HALF + 1; i < safc_pkg::LINE_SIZE; i++)
					lanes_q[i] <= lanes_q[i-1];
				lanes_q[safc_pkg::LINE_HALF].valid <= 1'b0;
				w_q <= empty_ent;
				s_q <= safc_pkg::LANE_W'(safc_pkg::LINE_HALF);
			end
		end else if (cmd.upd) begin
			lanes_q[s_q] <= new_ent;
		end
		if (push) begin
			pend_q <= push_res;
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (cmd.flush && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			sp_q     <= '0;
		end else begin
			out_v_q <= (out_v_q && !rec.ready) || ((push || cmd.flush) && pend_v_q);
			if (push) pend_v_q <= 1'b1;
			else if (cmd.flush) pend_v_q <= 1'b0;
			if (cmd.flush) sp_q <= sp_q + safc_pkg::ADDR_W'(safc_pkg::LINE_HALF);
		end
	end

	assign rec.valid          = out_v_q;
	assign rec.out_hash       = out_q.hash;
	assign rec.out_reason     = out_q.reason;
	assign rec.out_packets    = out_q.packets;
	assign rec.out_first_seen = out_q.first_seen;
	assign rec.out_last_seen  = out_q.last_seen;
	assign rec.out_flags      = out_q.flags;
	assign rec.out_last       = out_last_q;

endmodule
`default_nettype wire
